// ===== design/trd_pkg.sv =====
// ============================================================================
// trd_pkg - shared types and constants of the touch report decoder
// Action and result codes, field widths, configuration and result records.
// ============================================================================
package trd_pkg;

    localparam int MAX_POINTS       = 10;
    localparam int MAX_REPORT_BYTES = 64;

    localparam int LEN_W   = 7;
    localparam int CNT_W   = 4;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_CLEAR     = 3'd1;
    localparam logic [2:0] ACT_EXIT_BIOS = 3'd2;
    localparam logic [2:0] ACT_START_CPU = 3'd3;
    localparam logic [2:0] ACT_READ      = 3'd4;

    localparam logic [1:0] RES_STATUS = 2'd0;
    localparam logic [1:0] RES_POINT  = 2'd1;
    localparam logic [1:0] RES_DONE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS    = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [7:0] GESTURE_HEADER = 8'hF6;
    localparam logic [7:0] POINT_HEADER_MAX = 8'h0A;
    localparam logic [LEN_W-1:0] HEADER_BYTES = 7'd4;
    localparam logic [LEN_W-1:0] GESTURE_INDEX = 7'd6;
    localparam logic [LEN_W-1:0] POINT_MIN_LEN = 7'd10;
    localparam logic [LEN_W-1:0] GESTURE_MIN_LEN = 7'd7;

    typedef struct packed {
        logic [DIM_W-1:0] screen_width;
        logic [DIM_W-1:0] screen_height;
        logic [1:0]       rotation;
        logic [CNT_W-1:0] max_report_points;
    } trd_cfg_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         result_kind;
        logic [2:0]         action;
        logic [LEN_W-1:0]   read_length;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [7:0]         touch_id;
        logic [7:0]         strength;
        logic [CNT_W-1:0]   point_count;
        logic [2:0]         gesture;
    } trd_result_t;

    // full 6-byte records after the header: (len - 4) / 6 via reciprocal 43/256
    function automatic logic [CNT_W-1:0] record_count(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] body;
        logic [LEN_W+5:0] prod;
        logic [4:0]       quot;
        body = len - HEADER_BYTES;
        prod = (LEN_W+6)'(body) * (LEN_W+6)'(43);
        quot = prod[LEN_W+5:8];
        if (len < POINT_MIN_LEN) begin
            record_count = '0;
        end else if (quot > 5'(MAX_POINTS)) begin
            record_count = CNT_W'(MAX_POINTS);
        end else begin
            record_count = CNT_W'(quot);
        end
    endfunction

endpackage

// ===== design/touch_report_decoder.sv =====
// Path: input register, decoder, result register. Throughput: one item per
// cycle while m_ready does not stall; the input and result registers decouple
// the two channels, so a new item is taken while a result waits.
// Reset: all report state and handshake flags cleared; panel registers return
// to 412 x 412, no rotation, ten points per report.
// ============================================================================
// touch_report_decoder - touch controller status and report decoder
// Input register, decoder with report state, result register, config bank.
// ============================================================================
module touch_report_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [31:0]                         s_status_word,
    input  logic [7:0]                          s_report_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_result_kind,
    output logic [2:0]                          m_action,
    output logic [trd_pkg::LEN_W-1:0]           m_read_length,
    output logic [trd_pkg::COORD_W-1:0]         m_point_x,
    output logic [trd_pkg::COORD_W-1:0]         m_point_y,
    output logic [7:0]                          m_touch_id,
    output logic [7:0]                          m_strength,
    output logic [trd_pkg::CNT_W-1:0]           m_point_count,
    output logic [2:0]                          m_gesture,
    input  logic                                cfg_wr_en,
    input  logic [trd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trd_pkg::CFG_W-1:0]           cfg_wr_data
);

    trd_pkg::trd_cfg_t    cfg_reg;
    trd_pkg::trd_result_t res;
    trd_pkg::trd_result_t out_reg;

    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [31:0] in_status_reg;
    logic [7:0]  in_byte_reg;
    logic        m_valid_reg;
    logic        out_free;
    logic        fire;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // configuration bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width      <= trd_pkg::DIM_W'(412);
            cfg_reg.screen_height     <= trd_pkg::DIM_W'(412);
            cfg_reg.rotation          <= trd_pkg::ROT_0;
            cfg_reg.max_report_points <= trd_pkg::CNT_W'(trd_pkg::MAX_POINTS);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                trd_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_wr_data;
                trd_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_wr_data;
                trd_pkg::REG_ROTATION:      cfg_reg.rotation      <= cfg_wr_data[1:0];
                trd_pkg::REG_MAX_POINTS: begin
                    cfg_reg.max_report_points <= cfg_wr_data[trd_pkg::CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register: hold until the decoder takes the item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg   <= s_kind;
            in_status_reg <= s_status_word;
            in_byte_reg   <= s_report_byte;
        end
    end

    trd_decoder u_decoder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .kind        (in_kind_reg),
        .status_word (in_status_reg),
        .report_byte (in_byte_reg),
        .cfg         (cfg_reg),
        .res         (res)
    );

    // result register: advance when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= fire && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && out_free) begin
            out_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = out_reg.result_kind;
    assign m_action      = out_reg.action;
    assign m_read_length = out_reg.read_length;
    assign m_point_x     = out_reg.point_x;
    assign m_point_y     = out_reg.point_y;
    assign m_touch_id    = out_reg.touch_id;
    assign m_strength    = out_reg.strength;
    assign m_point_count = out_reg.point_count;
    assign m_gesture     = out_reg.gesture;

endmodule

// ===== design/trd_decoder.sv =====
// ============================================================================
// trd_decoder - status and report byte decoder
// Holds the report state and forms at most one result for each item.
// ============================================================================
module trd_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic                kind,
    input  logic [31:0]         status_word,
    input  logic [7:0]          report_byte,
    input  trd_pkg::trd_cfg_t   cfg,
    output trd_pkg::trd_result_t res
);

    logic                           receiving_reg, receiving_next;
    logic                           point_flag_reg, point_flag_next;
    logic                           gesture_flag_reg, gesture_flag_next;
    logic [trd_pkg::LEN_W-1:0]      exp_len_reg, exp_len_next;
    logic [trd_pkg::LEN_W-1:0]      byte_index_reg, byte_index_next;
    logic [2:0]                     record_byte_reg, record_byte_next;
    logic [trd_pkg::CNT_W-1:0]      records_left_reg, records_left_next;
    logic [trd_pkg::CNT_W-1:0]      emitted_reg, emitted_next;
    logic [7:0]                     header4_reg, header4_next;
    logic [31:0]                    staged_reg, staged_next;
    logic [2:0]                     gesture_reg, gesture_next;

    always_comb begin
        logic [7:0]                  b0;
        logic [7:0]                  b1;
        logic [15:0]                 len;
        logic [2:0]                  act;
        logic [7:0]                  hdr;
        logic                        pm;
        logic [trd_pkg::CNT_W-1:0]   limit;
        logic [trd_pkg::COORD_W-1:0] x;
        logic [trd_pkg::COORD_W-1:0] y;
        logic [trd_pkg::DIM_W-1:0]   rx;
        logic [trd_pkg::DIM_W-1:0]   ry;
        logic [trd_pkg::LEN_W:0]     idx_inc;

        receiving_next    = receiving_reg;
        point_flag_next   = point_flag_reg;
        gesture_flag_next = gesture_flag_reg;
        exp_len_next      = exp_len_reg;
        byte_index_next   = byte_index_reg;
        record_byte_next  = record_byte_reg;
        records_left_next = records_left_reg;
        emitted_next      = emitted_reg;
        header4_next      = header4_reg;
        staged_next       = staged_reg;
        gesture_next      = gesture_reg;
        res               = '0;

        b0      = status_word[7:0];
        b1      = status_word[15:8];
        len     = status_word[31:16];
        act     = trd_pkg::ACT_NONE;
        hdr     = (byte_index_reg == trd_pkg::HEADER_BYTES) ? report_byte : header4_reg;
        pm      = point_flag_reg && (exp_len_reg >= trd_pkg::POINT_MIN_LEN)
                  && (hdr <= trd_pkg::POINT_HEADER_MAX);
        limit   = (cfg.max_report_points > trd_pkg::CNT_W'(trd_pkg::MAX_POINTS))
                  ? trd_pkg::CNT_W'(trd_pkg::MAX_POINTS) : cfg.max_report_points;
        x       = {staged_reg[31:28], staged_reg[15:8]};
        y       = {staged_reg[27:24], staged_reg[23:16]};
        rx      = trd_pkg::DIM_W'(x);
        ry      = trd_pkg::DIM_W'(y);
        idx_inc = {1'b0, byte_index_reg} + 1'b1;

        case (cfg.rotation)
            trd_pkg::ROT_90: begin
                rx = cfg.screen_height - 1'b1 - trd_pkg::DIM_W'(y);
                ry = trd_pkg::DIM_W'(x);
            end
            trd_pkg::ROT_180: begin
                rx = cfg.screen_width - 1'b1 - trd_pkg::DIM_W'(x);
                ry = cfg.screen_height - 1'b1 - trd_pkg::DIM_W'(y);
            end
            trd_pkg::ROT_270: begin
                rx = trd_pkg::DIM_W'(y);
                ry = cfg.screen_width - 1'b1 - trd_pkg::DIM_W'(x);
            end
            default: begin
            end
        endcase

        if (fire && !kind) begin
            receiving_next    = 1'b0;
            point_flag_next   = 1'b0;
            gesture_flag_next = 1'b0;
            exp_len_next      = '0;
            byte_index_next   = '0;
            record_byte_next  = '0;
            records_left_next = '0;
            emitted_next      = '0;
            header4_next      = '0;
            staged_next       = '0;
            gesture_next      = '0;

            if (b1[6]) begin
                act = trd_pkg::ACT_EXIT_BIOS;
            end else if (b1[5]) begin
                act = trd_pkg::ACT_START_CPU;
            end else if (b1[3] && len == 16'd0) begin
                act = trd_pkg::ACT_CLEAR;
            end else if (!b0[0] && !b0[1]) begin
                act = (b1[3] && b0[3]) ? trd_pkg::ACT_CLEAR : trd_pkg::ACT_NONE;
            end else if (len < 16'(trd_pkg::HEADER_BYTES)
                         || len > 16'(trd_pkg::MAX_REPORT_BYTES)) begin
                act = trd_pkg::ACT_CLEAR;
            end else begin
                act = trd_pkg::ACT_READ;
            end

            res.valid       = 1'b1;
            res.result_kind = trd_pkg::RES_STATUS;
            res.action      = act;
            if (act == trd_pkg::ACT_READ) begin
                receiving_next    = 1'b1;
                point_flag_next   = b0[0];
                gesture_flag_next = b0[1];
                exp_len_next      = len[trd_pkg::LEN_W-1:0];
                records_left_next = trd_pkg::record_count(len[trd_pkg::LEN_W-1:0]);
                res.read_length   = len[trd_pkg::LEN_W-1:0];
            end
        end else if (fire && receiving_reg) begin
            if (byte_index_reg == trd_pkg::HEADER_BYTES) begin
                header4_next = report_byte;
            end

            if (byte_index_reg >= trd_pkg::HEADER_BYTES && records_left_reg != '0) begin
                if (record_byte_reg < 3'd4) begin
                    staged_next[{record_byte_reg[1:0], 3'b000} +: 8] =
                        staged_reg[{record_byte_reg[1:0], 3'b000} +: 8] | report_byte;
                    record_byte_next = record_byte_reg + 1'b1;
                end else if (record_byte_reg == 3'd4) begin
                    if (pm && emitted_reg < limit && report_byte != 8'd0
                        && trd_pkg::DIM_W'(x) < cfg.screen_width
                        && trd_pkg::DIM_W'(y) < cfg.screen_height) begin
                        emitted_next    = emitted_reg + 1'b1;
                        res.valid       = 1'b1;
                        res.result_kind = trd_pkg::RES_POINT;
                        res.point_x     = rx[trd_pkg::COORD_W-1:0];
                        res.point_y     = ry[trd_pkg::COORD_W-1:0];
                        res.touch_id    = staged_reg[7:0];
                        res.strength    = report_byte;
                    end
                    record_byte_next = 3'd5;
                end else begin
                    record_byte_next  = '0;
                    staged_next       = '0;
                    records_left_next = records_left_reg - 1'b1;
                end
            end

            if (byte_index_reg == trd_pkg::GESTURE_INDEX && !pm && gesture_flag_reg
                && exp_len_reg >= trd_pkg::GESTURE_MIN_LEN
                && hdr == trd_pkg::GESTURE_HEADER) begin
                gesture_next = report_byte[2:0];
            end

            byte_index_next = idx_inc[trd_pkg::LEN_W-1:0];
            if (idx_inc >= {1'b0, exp_len_reg}) begin
                receiving_next  = 1'b0;
                res             = '0;
                res.valid       = 1'b1;
                res.result_kind = trd_pkg::RES_DONE;
                res.point_count = emitted_next;
                res.gesture     = gesture_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg    <= 1'b0;
            point_flag_reg   <= 1'b0;
            gesture_flag_reg <= 1'b0;
            exp_len_reg      <= '0;
            byte_index_reg   <= '0;
            record_byte_reg  <= '0;
            records_left_reg <= '0;
            emitted_reg      <= '0;
            header4_reg      <= '0;
            staged_reg       <= '0;
            gesture_reg      <= '0;
        end else begin
            receiving_reg    <= receiving_next;
            point_flag_reg   <= point_flag_next;
            gesture_flag_reg <= gesture_flag_next;
            exp_len_reg      <= exp_len_next;
            byte_index_reg   <= byte_index_next;
            record_byte_reg  <= record_byte_next;
            records_left_reg <= records_left_next;
            emitted_reg      <= emitted_next;
            header4_reg      <= header4_next;
            staged_reg       <= staged_next;
            gesture_reg      <= gesture_next;
        end
    end

endmodule

// ===== bench/trd_tb_pkg.sv =====
`timescale 1ns / 100ps
// ============================================================================
// trd_tb_pkg - predictor and scoreboard for the touch report decoder bench
// Tracks report state and panel registers, predicts the result of each
// accepted transfer and checks returned results in order, field by field.
// ============================================================================
package trd_tb_pkg;

    import trd_pkg::*;

    // status word bit positions
    localparam int STAT_POINT   = 0;
    localparam int STAT_GESTURE = 1;
    localparam int STAT_AUX     = 3;
    localparam int STAT_RUN     = 11;
    localparam int STAT_CPU     = 13;
    localparam int STAT_BIOS    = 14;

    localparam int RECORD_BYTES = 6;

    class touch_scoreboard;

        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [1:0]       rot;
        logic [CNT_W-1:0] pts_limit;

        bit               receiving;
        bit               pt_flag;
        bit               ge_flag;
        logic [LEN_W-1:0] exp_len;
        logic [LEN_W-1:0] byte_idx;
        logic [2:0]       rec_pos;
        logic [CNT_W-1:0] recs_left;
        logic [CNT_W-1:0] emitted;
        logic [7:0]       hdr4;
        logic [31:0]      staged;
        logic [2:0]       gest;

        trd_result_t      pending_events[$];
        int               errors;

        function new();
            width     = 13'd412;
            height    = 13'd412;
            rot       = ROT_0;
            pts_limit = 4'd10;
            errors    = 0;
            clear_report();
        endfunction

        function void clear_report();
            receiving = 0;
            pt_flag   = 0;
            ge_flag   = 0;
            exp_len   = '0;
            byte_idx  = '0;
            rec_pos   = '0;
            recs_left = '0;
            emitted   = '0;
            hdr4      = '0;
            staged    = '0;
            gest      = '0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
            case (idx)
                REG_SCREEN_WIDTH:  width = data;
                REG_SCREEN_HEIGHT: height = data;
                REG_ROTATION:      rot = data[1:0];
                REG_MAX_POINTS:    pts_limit = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit point_mode();
            return pt_flag && exp_len >= POINT_MIN_LEN && hdr4 <= POINT_HEADER_MAX;
        endfunction

        function void decode_status(input logic [31:0] word, output trd_result_t res);
            logic [15:0] len;
            logic [2:0]  act;
            int          recs;
            len = word[31:16];
            clear_report();
            if (word[STAT_BIOS]) begin
                act = ACT_EXIT_BIOS;
            end else if (word[STAT_CPU]) begin
                act = ACT_START_CPU;
            end else if (word[STAT_RUN] && len == 0) begin
                act = ACT_CLEAR;
            end else if (!word[STAT_POINT] && !word[STAT_GESTURE]) begin
                act = (word[STAT_RUN] && word[STAT_AUX]) ? ACT_CLEAR : ACT_NONE;
            end else if (len < HEADER_BYTES || len > MAX_REPORT_BYTES) begin
                act = ACT_CLEAR;
            end else begin
                act = ACT_READ;
            end
            res             = '0;
            res.valid       = 1'b1;
            res.result_kind = RES_STATUS;
            res.action      = act;
            if (act == ACT_READ) begin
                receiving = 1;
                pt_flag   = word[STAT_POINT];
                ge_flag   = word[STAT_GESTURE];
                exp_len   = len[LEN_W-1:0];
                recs      = (len >= POINT_MIN_LEN) ?
                            (int'(len) - int'(HEADER_BYTES)) / RECORD_BYTES : 0;
                if (recs > MAX_POINTS) recs = MAX_POINTS;
                recs_left       = CNT_W'(recs);
                res.read_length = len[LEN_W-1:0];
            end
        endfunction

        function void take_report_byte(input logic [7:0] b, inout trd_result_t res,
                                       inout bit produced);
            int          idx;
            int          cap;
            logic [11:0] x;
            logic [11:0] y;
            int          rx;
            int          ry;
            idx = byte_idx;
            if (idx == HEADER_BYTES) hdr4 = b;
            if (idx >= HEADER_BYTES && recs_left != 0) begin
                if (rec_pos < 4) begin
                    staged  = staged | (32'(b) << (8 * rec_pos));
                    rec_pos = rec_pos + 3'd1;
                end else if (rec_pos == 4) begin
                    cap = (pts_limit > MAX_POINTS) ? MAX_POINTS : pts_limit;
                    if (point_mode() && emitted < cap) begin
                        x = {staged[31:28], staged[15:8]};
                        y = {staged[27:24], staged[23:16]};
                        if (b != 0 && x < width && y < height) begin
                            rx = x;
                            ry = y;
                            case (rot)
                                ROT_90: begin
                                    rx = int'(height) - 1 - int'(y);
                                    ry = x;
                                end
                                ROT_180: begin
                                    rx = int'(width) - 1 - int'(x);
                                    ry = int'(height) - 1 - int'(y);
                                end
                                ROT_270: begin
                                    rx = y;
                                    ry = int'(width) - 1 - int'(x);
                                end
                                default: ;
                            endcase
                            emitted         = emitted + 4'd1;
                            res             = '0;
                            res.valid       = 1'b1;
                            res.result_kind = RES_POINT;
                            res.point_x     = COORD_W'(rx);
                            res.point_y     = COORD_W'(ry);
                            res.touch_id    = staged[7:0];
                            res.strength    = b;
                            produced        = 1;
                        end
                    end
                    rec_pos = 3'd5;
                end else begin
                    rec_pos   = '0;
                    staged    = '0;
                    recs_left = recs_left - 4'd1;
                end
            end
            if (idx == GESTURE_INDEX && !point_mode() && ge_flag &&
                exp_len >= GESTURE_MIN_LEN && hdr4 == GESTURE_HEADER) begin
                gest = b[2:0];
            end
            byte_idx = LEN_W'(idx + 1);
            if (idx + 1 >= exp_len) begin
                receiving       = 0;
                res             = '0;
                res.valid       = 1'b1;
                res.result_kind = RES_DONE;
                res.point_count = emitted;
                res.gesture     = gest;
                produced        = 1;
            end
        endfunction

        // returns 0 for a byte that the block drops while idle
        function bit note_input(input logic kind, input logic [31:0] word,
                                input logic [7:0] rbyte);
            trd_result_t res;
            bit          produced;
            res      = '0;
            produced = 0;
            if (kind == 1'b0) begin
                decode_status(word, res);
                produced = 1;
            end else if (receiving) begin
                take_report_byte(rbyte, res, produced);
            end else begin
                return 0;
            end
            if (produced) pending_events.push_back(res);
            return 1;
        endfunction

        function void compare_field(input string field, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(input trd_result_t got);
            trd_result_t want;
            if (pending_events.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, got.result_kind);
                return;
            end
            want = pending_events.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("action", want.action, got.action);
            compare_field("read_length", want.read_length, got.read_length);
            compare_field("point_x", want.point_x, got.point_x);
            compare_field("point_y", want.point_y, got.point_y);
            compare_field("touch_id", want.touch_id, got.touch_id);
            compare_field("strength", want.strength, got.strength);
            compare_field("point_count", want.point_count, got.point_count);
            compare_field("gesture", want.gesture, got.gesture);
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

    endclass

endpackage

// ===== bench/touch_report_decoder_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// touch_report_decoder_tb - self-checking bench for the touch report decoder
// Sends status words and report byte streams over valid/ready, mostly well
// formed point and gesture reports with random content plus noise, under
// several panel settings and idling patterns, and checks every result.
// ============================================================================
module touch_report_decoder_tb;

    import trd_pkg::*;
    import trd_tb_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 65;
    localparam int HOLD_PHASE      = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 6;
    localparam int STALL_LIMIT     = 4000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_kind;
    logic [31:0]          s_status_word;
    logic [7:0]           s_report_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [1:0]           m_result_kind;
    logic [2:0]           m_action;
    logic [LEN_W-1:0]     m_read_length;
    logic [COORD_W-1:0]   m_point_x;
    logic [COORD_W-1:0]   m_point_y;
    logic [7:0]           m_touch_id;
    logic [7:0]           m_strength;
    logic [CNT_W-1:0]     m_point_count;
    logic [2:0]           m_gesture;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    touch_scoreboard sb;
    int unsigned     src_idle_pct;
    int unsigned     snk_stall_pct;
    int              items_sent;
    int              stall_cycles;
    bit              hold_req;
    bit              hold_done;

    logic [31:0] probe_words [7] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_2000, 32'h0000_0800,
        32'h0005_0808, 32'h0003_0001, 32'h0041_0002
    };
    // two records: one kept at the panel edge, one off the panel
    logic [7:0] demo_report [16] = '{
        8'h00, 8'hFF, 8'h00, 8'hFF,
        8'h03, 8'h9B, 8'h00, 8'h10, 8'hFF, 8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h80
    };

    touch_report_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_status_word (s_status_word),
        .s_report_byte (s_report_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_action      (m_action),
        .m_read_length (m_read_length),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_touch_id    (m_touch_id),
        .m_strength    (m_strength),
        .m_point_count (m_point_count),
        .m_gesture     (m_gesture),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1;
            end
            m_ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(trd_result_t'({1'b1, m_result_kind, m_action, m_read_length,
                                           m_point_x, m_point_y, m_touch_id, m_strength,
                                           m_point_count, m_gesture}));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(input logic kind, input logic [31:0] word,
                             input logic [7:0] rbyte);
        while ($urandom_range(99) < src_idle_pct) @(negedge aclk);
        s_kind        = kind;
        s_status_word = word;
        s_report_byte = rbyte;
        s_valid       = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (sb.note_input(kind, word, rbyte)) items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = CFG_W'(data);
        sb.set_register(idx, CFG_W'(data));
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic program_panel(input int unsigned w, input int unsigned h,
                                 input logic [1:0] r, input int unsigned pts);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_ROTATION, r);
        write_reg(REG_MAX_POINTS, pts);
    endtask

    task automatic settle();
        while (sb.outstanding() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        src_idle_pct  = (mode == IDLE_SENDER) ? 84 : (mode == IDLE_BOTH) ? 6 : 0;
        snk_stall_pct = (mode == IDLE_RECEIVER) ? 84 : (mode == IDLE_BOTH) ? 6 : 0;
    endtask

    // status word that starts a read, then the report, now and then cut short
    task automatic send_report(input bit gesture_report);
        int unsigned len;
        int unsigned recs;
        int unsigned cut;
        int unsigned xmax;
        int unsigned ymax;
        int unsigned i;
        int unsigned pos;
        logic [31:0] word;
        logic [7:0]  hdr;
        logic [7:0]  bval;
        logic [11:0] px;
        logic [11:0] py;
        logic [7:0]  weight;
        word = $urandom;
        word[STAT_CPU]  = 1'b0;
        word[STAT_BIOS] = 1'b0;
        if (gesture_report) begin
            word[STAT_GESTURE] = 1'b1;
            word[STAT_POINT]   = ($urandom_range(3) == 0);
            len  = ($urandom_range(7) == 0) ? $urandom_range(HEADER_BYTES, 6) :
                   ($urandom_range(3) == 0) ? $urandom_range(7, MAX_REPORT_BYTES) :
                                              $urandom_range(7, 16);
            hdr  = ($urandom_range(5) != 0) ? GESTURE_HEADER : 8'($urandom_range(255));
            recs = 0;
        end else begin
            word[STAT_POINT] = 1'b1;
            hdr  = ($urandom_range(9) != 0) ? 8'($urandom_range(POINT_HEADER_MAX)) :
                                              8'($urandom_range(11, 255));
            recs = ($urandom_range(4) == 0) ? $urandom_range(5, MAX_POINTS) :
                                              $urandom_range(1, 3);
            len  = HEADER_BYTES + RECORD_BYTES * recs + $urandom_range(5);
            if (len > MAX_REPORT_BYTES) len = MAX_REPORT_BYTES;
            if ($urandom_range(9) == 0) len = $urandom_range(HEADER_BYTES, MAX_REPORT_BYTES);
            recs = (len >= POINT_MIN_LEN) ? (len - HEADER_BYTES) / RECORD_BYTES : 0;
            if (recs > MAX_POINTS) recs = MAX_POINTS;
        end
        word[31:16] = 16'(len);
        xmax = (sb.width > 4096) ? 4096 : sb.width;
        ymax = (sb.height > 4096) ? 4096 : sb.height;
        cut  = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : len;
        send_item(1'b0, word, 8'($urandom_range(255)));
        for (i = 0; i < cut; i++) begin
            bval = 8'($urandom_range(255));
            if (i >= HEADER_BYTES && (i - HEADER_BYTES) / RECORD_BYTES < recs) begin
                pos = (i - HEADER_BYTES) % RECORD_BYTES;
                if (pos == 0) begin
                    if ($urandom_range(4) != 0) begin
                        px = 12'($urandom_range(xmax - 1));
                        py = 12'($urandom_range(ymax - 1));
                    end else begin
                        px = 12'($urandom_range(4095));
                        py = 12'($urandom_range(4095));
                    end
                    weight = ($urandom_range(6) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                end
                case (pos)
                    1: bval = px[7:0];
                    2: bval = py[7:0];
                    3: bval = {px[11:8], py[11:8]};
                    4: bval = weight;
                    default: ;
                endcase
            end
            if (i == HEADER_BYTES) bval = hdr;
            send_item(1'b1, $urandom, bval);
        end
    endtask

    initial begin
        logic [31:0] word;
        int unsigned r;
        int          phase;
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = 1'b0;
        s_status_word = '0;
        s_report_byte = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_SCREEN_WIDTH;
        cfg_wr_data   = '0;
        hold_req      = 0;
        items_sent    = 0;
        set_idle(IDLE_NONE);
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        send_item(1'b1, '0, 8'hFF);
        foreach (probe_words[k]) send_item(1'b0, probe_words[k], 8'h00);
        send_item(1'b0, {16'd16, 8'h00, 8'h01}, 8'h00);
        foreach (demo_report[k]) send_item(1'b1, '0, demo_report[k]);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0: program_panel(412, 412, ROT_0, 10);
                1: program_panel(4096, 4096, ROT_90, 1);
                2: program_panel(1, 1, ROT_180, MAX_POINTS);
                3: program_panel(8191, 8191, ROT_270, 15);
                4: program_panel($urandom_range(1, 4096), $urandom_range(1, 4096),
                                 2'($urandom_range(3)), 0);
                default: program_panel($urandom_range(1, 4096), $urandom_range(1, 4096),
                                       2'($urandom_range(3)), $urandom_range(1, MAX_POINTS));
            endcase
            set_idle(idle_mode_t'(phase % 4));
            if (phase == HOLD_PHASE) hold_req = 1;
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) begin
                r = $urandom_range(99);
                if (r < 55) begin
                    send_report(1'b0);
                end else if (r < 75) begin
                    send_report(1'b1);
                end else if (r < 90) begin
                    word = $urandom;
                    if ($urandom_range(1) != 0) word[STAT_BIOS] = 1'b0;
                    if ($urandom_range(1) != 0) word[STAT_CPU] = 1'b0;
                    case ($urandom_range(3))
                        0: word[31:16] = '0;
                        1: word[31:16] = 16'($urandom_range(1, 3));
                        2: word[31:16] = 16'($urandom_range(HEADER_BYTES, MAX_REPORT_BYTES));
                        default: ;
                    endcase
                    send_item(1'b0, word, 8'($urandom_range(255)));
                end else begin
                    send_item(1'b1, $urandom, 8'($urandom_range(255)));
                end
            end
        end

        settle();
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/trd_pkg.sv
design/trd_decoder.sv
design/touch_report_decoder.sv
bench/trd_tb_pkg.sv
bench/touch_report_decoder_tb.sv
